// ===== sv/fbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// fbcd_pkg: shared types and constants
// Field widths, configuration register codes and the structs that pass
// between the lanes, the square-root pipeline and the output buffer.
// ----------------------------------------------------------------------------
package fbcd_pkg;

  localparam int NumAxes   = 3;
  localparam int DimW      = 2;
  localparam int CoordW    = 32;
  localparam int BinW      = 10;
  localparam int SizeW     = 21;
  localparam int MagW      = 31;
  localparam int SqW       = 2 * MagW;
  localparam int SumW      = 64;
  localparam int RootW     = SumW / 2;
  localparam int SqrtSteps = RootW;
  localparam int CfgIdxW   = 3;
  localparam int DiffW     = 36;

  localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};

  localparam logic [DimW-1:0] DimsReset = 2'd3;
  localparam logic [SizeW-1:0] SizeReset = 21'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIMENSIONS = 3'd0,
    CFG_LOWER_X    = 3'd1,
    CFG_LOWER_Y    = 3'd2,
    CFG_LOWER_Z    = 3'd3,
    CFG_SIZE_X     = 3'd4,
    CFG_SIZE_Y     = 3'd5,
    CFG_SIZE_Z     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [SqW-1:0]  sq;
    logic [MagW-1:0] mag;
    logic            sat;
  } lane_res_t;

  typedef struct packed {
    logic            one_d;
    logic [MagW-1:0] mag;
    logic            sat;
  } side_t;

  typedef struct packed {
    logic [RootW-1:0] distance;
    logic             sat;
  } out_t;

endpackage

// ===== sv/fbcd_lane.sv =====
// ----------------------------------------------------------------------------
// fbcd_lane: one axis of the farthest-corner datapath
// Four stages: bin face product, offset to lower face, larger clipped
// face offset, square of that offset.
// ----------------------------------------------------------------------------
module fbcd_lane #(
  parameter int BINS_PER_AXIS = 1024
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [fbcd_pkg::CoordW-1:0]  point_i,
  input  logic        [fbcd_pkg::BinW-1:0]    bin_i,
  input  logic signed [fbcd_pkg::CoordW-1:0]  lower_i,
  input  logic        [fbcd_pkg::SizeW-1:0]   size_i,
  output fbcd_pkg::lane_res_t                 res_o
);

  localparam int ProdW = fbcd_pkg::BinW + fbcd_pkg::SizeW;
  localparam logic [16:0] BinMax = 17'(BINS_PER_AXIS - 1);

  logic        [fbcd_pkg::BinW-1:0]    bin_c;
  logic        [ProdW-1:0]             prod_q;
  logic signed [fbcd_pkg::CoordW-1:0]  pt_q;
  logic signed [fbcd_pkg::DiffW-1:0]   lo_w;
  logic signed [fbcd_pkg::DiffW-1:0]   d0_d;
  logic signed [fbcd_pkg::DiffW-1:0]   d0_q;
  logic signed [fbcd_pkg::DiffW-1:0]   d1_w;
  logic        [fbcd_pkg::DiffW-1:0]   a0_w;
  logic        [fbcd_pkg::DiffW-1:0]   a1_w;
  logic        [fbcd_pkg::DiffW-1:0]   m_w;
  logic                                sat_d;
  logic        [fbcd_pkg::MagW-1:0]    mag_d;
  logic        [fbcd_pkg::MagW-1:0]    mag_q;
  logic                                sat_q;
  fbcd_pkg::lane_res_t                 res_q;

  // clamp bins past the grid edge to the last bin
  assign bin_c = ({7'd0, bin_i} > BinMax) ? BinMax[fbcd_pkg::BinW-1:0] : bin_i;

  assign lo_w = $signed({{(fbcd_pkg::DiffW-ProdW){1'b0}}, prod_q})
              + fbcd_pkg::DiffW'(lower_i);
  assign d0_d = fbcd_pkg::DiffW'(pt_q) - lo_w;

  assign d1_w = d0_q - $signed({{(fbcd_pkg::DiffW-fbcd_pkg::SizeW){1'b0}}, size_i});
  assign a0_w = d0_q[fbcd_pkg::DiffW-1] ? unsigned'(-d0_q) : unsigned'(d0_q);
  assign a1_w = d1_w[fbcd_pkg::DiffW-1] ? unsigned'(-d1_w) : unsigned'(d1_w);
  assign m_w  = (a0_w > a1_w) ? a0_w : a1_w;
  assign sat_d = m_w > fbcd_pkg::DiffW'(fbcd_pkg::MagMax);
  assign mag_d = sat_d ? fbcd_pkg::MagMax : m_w[fbcd_pkg::MagW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= ProdW'(bin_c) * ProdW'(size_i);
      pt_q      <= point_i;
      d0_q      <= d0_d;
      mag_q     <= mag_d;
      sat_q     <= sat_d;
      res_q.sq  <= fbcd_pkg::SqW'(mag_q) * fbcd_pkg::SqW'(mag_q);
      res_q.mag <= mag_q;
      res_q.sat <= sat_q;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/fbcd_sqrt.sv =====
// ----------------------------------------------------------------------------
// fbcd_sqrt: pipelined integer square root
// One result bit per stage, most significant first; the floor of the
// square root of a 64-bit value comes out after 32 stages.
// ----------------------------------------------------------------------------
module fbcd_sqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [fbcd_pkg::SumW-1:0]         value_i,
  input  fbcd_pkg::side_t                   side_i,
  output logic                              valid_o,
  output logic [fbcd_pkg::RootW-1:0]        root_o,
  output fbcd_pkg::side_t                   side_o
);

  localparam int Steps = fbcd_pkg::SqrtSteps;
  localparam int TrialW = fbcd_pkg::SumW + 2;

  logic [fbcd_pkg::SumW-1:0]  rem_q  [Steps+1];
  logic [fbcd_pkg::RootW-1:0] root_q [Steps+1];
  fbcd_pkg::side_t            side_q [Steps+1];
  logic [Steps:0]             vld_q;

  assign rem_q[0]  = value_i;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;
  assign vld_q[0]  = valid_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Bit = Steps - 1 - k;

    logic [TrialW-1:0] trial;
    logic              take;

    // (root + 2^Bit)^2 - root^2 = root * 2^(Bit+1) + 2^(2*Bit)
    assign trial = (TrialW'(root_q[k]) << (Bit + 1)) + (TrialW'(1) << (2 * Bit));
    assign take  = TrialW'(rem_q[k]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? fbcd_pkg::SumW'(TrialW'(rem_q[k]) - trial) : rem_q[k];
        root_q[k+1] <= take ? (root_q[k] | (fbcd_pkg::RootW'(1) << Bit)) : root_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign root_o  = root_q[Steps];
  assign side_o  = side_q[Steps];

endmodule

// ===== sv/fbcd_outbuf.sv =====
// ----------------------------------------------------------------------------
// fbcd_outbuf: output register with skid stage
// Holds the result on the output while a second entry catches the item
// that the pipeline delivers in the cycle the downstream stalls.
// ----------------------------------------------------------------------------
module fbcd_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  fbcd_pkg::out_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           ready_i,
  output fbcd_pkg::out_t data_o
);

  logic           ov_q;
  logic           sv_q;
  fbcd_pkg::out_t od_q;
  fbcd_pkg::out_t sd_q;

  assign ready_o = !sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!ov_q || ready_i) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= 1'b0;
      end else begin
        ov_q <= valid_i;
      end
    end else if (valid_i) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || ready_i) begin
      od_q <= sv_q ? sd_q : data_i;
    end else if (valid_i && !sv_q) begin
      sd_q <= data_i;
    end
  end

  assign valid_o = ov_q;
  assign data_o  = od_q;

endmodule

// ===== sv/farthest_bin_corner_distance_top.sv =====
// ----------------------------------------------------------------------------
// farthest_bin_corner_distance_top: distance to the farthest bin corner
// Three axis lanes, a merge stage that sums the squares in use, a pipelined
// square root and an output buffer with skid stage.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while not stalled; every lane stage and
// each of the 32 square-root stages is registered, so nothing iterates.
// The pipeline stalls only while both output buffer entries are full.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets dimensions
// to 3, lower bounds to 0 and bin sizes to 1.0.
module farthest_bin_corner_distance_top #(
  parameter int BINS_PER_AXIS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [fbcd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic        [fbcd_pkg::CoordW-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [fbcd_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [fbcd_pkg::CoordW-1:0]  point_y_i,
  input  logic signed [fbcd_pkg::CoordW-1:0]  point_z_i,
  input  logic        [fbcd_pkg::BinW-1:0]    bin_x_i,
  input  logic        [fbcd_pkg::BinW-1:0]    bin_y_i,
  input  logic        [fbcd_pkg::BinW-1:0]    bin_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic        [fbcd_pkg::RootW-1:0]   distance_o,
  output logic                                saturated_o
);

  localparam int LaneStages = 4;

  logic        [fbcd_pkg::DimW-1:0]   dims_q;
  logic signed [fbcd_pkg::CoordW-1:0] lower_q [fbcd_pkg::NumAxes];
  logic        [fbcd_pkg::SizeW-1:0]  size_q  [fbcd_pkg::NumAxes];

  logic signed [fbcd_pkg::CoordW-1:0] point [fbcd_pkg::NumAxes];
  logic        [fbcd_pkg::BinW-1:0]   bin   [fbcd_pkg::NumAxes];
  fbcd_pkg::lane_res_t                res   [fbcd_pkg::NumAxes];

  logic                        en;
  logic [LaneStages-1:0]       lv_q;
  logic                        sum_v_q;
  logic [fbcd_pkg::SumW-1:0]   sum_q;
  fbcd_pkg::side_t             side_q;
  logic                        use_y;
  logic                        use_z;
  logic                        sq_v;
  logic [fbcd_pkg::RootW-1:0]  root;
  fbcd_pkg::side_t             sq_side;
  fbcd_pkg::out_t              res_out;
  fbcd_pkg::out_t              buf_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= fbcd_pkg::DimsReset;
      for (int a = 0; a < fbcd_pkg::NumAxes; a++) begin
        lower_q[a] <= '0;
        size_q[a]  <= fbcd_pkg::SizeReset;
      end
    end else if (cfg_we_i) begin
      case (fbcd_pkg::cfg_reg_e'(cfg_idx_i))
        fbcd_pkg::CFG_DIMENSIONS: dims_q     <= cfg_data_i[fbcd_pkg::DimW-1:0];
        fbcd_pkg::CFG_LOWER_X:    lower_q[0] <= cfg_data_i;
        fbcd_pkg::CFG_LOWER_Y:    lower_q[1] <= cfg_data_i;
        fbcd_pkg::CFG_LOWER_Z:    lower_q[2] <= cfg_data_i;
        fbcd_pkg::CFG_SIZE_X:     size_q[0]  <= cfg_data_i[fbcd_pkg::SizeW-1:0];
        fbcd_pkg::CFG_SIZE_Y:     size_q[1]  <= cfg_data_i[fbcd_pkg::SizeW-1:0];
        fbcd_pkg::CFG_SIZE_Z:     size_q[2]  <= cfg_data_i[fbcd_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  assign point[0] = point_x_i;
  assign point[1] = point_y_i;
  assign point[2] = point_z_i;
  assign bin[0]   = bin_x_i;
  assign bin[1]   = bin_y_i;
  assign bin[2]   = bin_z_i;

  for (genvar a = 0; a < fbcd_pkg::NumAxes; a++) begin : g_lane
    fbcd_lane #(
      .BINS_PER_AXIS(BINS_PER_AXIS)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .point_i (point[a]),
      .bin_i   (bin[a]),
      .lower_i (lower_q[a]),
      .size_i  (size_q[a]),
      .res_o   (res[a])
    );
  end

  assign in_ready_o = en;

  // a dimension code of zero runs as 1-D
  assign use_y = dims_q >= 2'd2;
  assign use_z = dims_q == 2'd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q    <= '0;
      sum_v_q <= 1'b0;
    end else if (en) begin
      lv_q    <= {lv_q[LaneStages-2:0], in_valid_i};
      sum_v_q <= lv_q[LaneStages-1];
    end
  end

  // Merge: add the squares of the axes in use
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= fbcd_pkg::SumW'(res[0].sq)
             + (use_y ? fbcd_pkg::SumW'(res[1].sq) : '0)
             + (use_z ? fbcd_pkg::SumW'(res[2].sq) : '0);
      side_q.one_d <= !use_y;
      side_q.mag   <= res[0].mag;
      side_q.sat   <= res[0].sat | (use_y & res[1].sat) | (use_z & res[2].sat);
    end
  end

  fbcd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sum_v_q),
    .value_i (sum_q),
    .side_i  (side_q),
    .valid_o (sq_v),
    .root_o  (root),
    .side_o  (sq_side)
  );

  assign res_out.distance = sq_side.one_d ? fbcd_pkg::RootW'(sq_side.mag) : root;
  assign res_out.sat      = sq_side.sat;

  fbcd_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .data_i  (res_out),
    .ready_o (en),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (buf_out)
  );

  assign distance_o  = buf_out.distance;
  assign saturated_o = buf_out.sat;

endmodule

// ===== sv/fbcd_checker.sv =====
// ----------------------------------------------------------------------------
// fbcd_checker: port-level checks for the farthest-corner block
// Output handshake rules, back-pressure relation, reset and the meaning
// of the saturation flag.
// ----------------------------------------------------------------------------
module fbcd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [fbcd_pkg::RootW-1:0]        distance_o,
  input logic                              saturated_o
);

  // hold a stalled result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(distance_o) && $stable(saturated_o))
    else $error("stalled result changed");

  // requests back up only behind a waiting result
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("request refused with no result waiting");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("block not empty after reset");

  // a clipped offset alone already reaches the largest magnitude
  a_sat_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> distance_o >= 32'h7FFF_FFFF)
    else $error("saturated result below clipped magnitude");

endmodule

bind farthest_bin_corner_distance_top fbcd_checker u_fbcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .distance_o  (distance_o),
  .saturated_o (saturated_o)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for farthest_bin_corner_distance_top
// Directed corner requests, then randomized register settings and requests
// with idle gaps on both sides. Expected distances come from a behavioral
// predictor; every result is matched in order against it.
// ----------------------------------------------------------------------------
module tb;
  import fbcd_pkg::*;

  localparam int BinsPerAxis  = 1024;
  localparam int LatencyCyc   = 37;
  localparam int RxHoldCycles = 300;
  localparam int IdlePct      = 14;

  typedef struct packed {
    logic [NumAxes-1:0][CoordW-1:0] pt;
    logic [NumAxes-1:0][BinW-1:0]   bin;
  } bin_query_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CoordW-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [CoordW-1:0]    point_x_i = '0;
  logic [CoordW-1:0]    point_y_i = '0;
  logic [CoordW-1:0]    point_z_i = '0;
  logic [BinW-1:0]      bin_x_i = '0;
  logic [BinW-1:0]      bin_y_i = '0;
  logic [BinW-1:0]      bin_z_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [RootW-1:0]     distance_o;
  logic                 saturated_o;

  // grid registers as the block should hold them
  logic [DimW-1:0]          grid_dims;
  logic signed [CoordW-1:0] grid_lower [NumAxes];
  logic [SizeW-1:0]         grid_size [NumAxes];

  bin_query_t query_q[$];
  out_t       dist_q[$];

  bit quiet = 1'b0;
  bit req_taken = 1'b0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_sat = 0;
  int n_settings = 0;

  farthest_bin_corner_distance_top #(
    .BINS_PER_AXIS(BinsPerAxis)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .bin_x_i    (bin_x_i),
    .bin_y_i    (bin_y_i),
    .bin_z_i    (bin_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .distance_o (distance_o),
    .saturated_o(saturated_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_t far_corner_dist(bin_query_t q);
    int unsigned axes;
    longint p, b, sz, lo, d0, d1, m;
    longint unsigned sq_sum, trial;
    logic [RootW-1:0] root;
    out_t r;
    axes = (grid_dims == 0) ? 1 : grid_dims;
    r = '0;
    sq_sum = 0;
    m = 0;
    for (int a = 0; a < axes; a++) begin
      p = longint'($signed(q.pt[a]));
      b = longint'(q.bin[a]);
      if (b > BinsPerAxis - 1) b = BinsPerAxis - 1;
      sz = longint'(grid_size[a]);
      lo = b * sz + longint'(grid_lower[a]);
      d0 = p - lo;
      d1 = d0 - sz;
      if (d0 < 0) d0 = -d0;
      if (d1 < 0) d1 = -d1;
      m = (d0 > d1) ? d0 : d1;
      if (m > longint'(MagMax)) begin
        m = longint'(MagMax);
        r.sat = 1'b1;
      end
      sq_sum += longint'(m) * longint'(m);
    end
    if (axes == 1) begin
      r.distance = m[RootW-1:0];
    end else begin
      // restore one root bit at a time, most significant first
      root = '0;
      for (int i = RootW - 1; i >= 0; i--) begin
        trial = {32'b0, root} | (64'd1 << i);
        if (trial * trial <= sq_sum) root = trial[RootW-1:0];
      end
      r.distance = root;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // sample request handshake
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      dist_q.push_back(far_corner_dist(query_q[0]));
      void'(query_q.pop_front());
      req_taken = 1'b1;
      n_sent++;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (query_q.size() > 0 && (quiet || $urandom_range(0, 99) >= IdlePct)) begin
        in_valid_i <= 1'b1;
        point_x_i  <= query_q[0].pt[0];
        point_y_i  <= query_q[0].pt[1];
        point_z_i  <= query_q[0].pt[2];
        bin_x_i    <= query_q[0].bin[0];
        bin_y_i    <= query_q[0].bin[1];
        bin_z_i    <= query_q[0].bin[2];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // result ready, with long holds on demand
  always @(negedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = RxHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dist_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result distance=%h sat=%b",
                                  distance_o, saturated_o));
      end else begin
        want = dist_q.pop_front();
        if (distance_o !== want.distance)
          report_mismatch($sformatf("result %0d distance got %h want %h",
                                    n_checked, distance_o, want.distance));
        if (saturated_o !== want.sat)
          report_mismatch($sformatf("result %0d saturated got %b want %b",
                                    n_checked, saturated_o, want.sat));
        if (want.sat) n_sat++;
      end
      n_checked++;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CoordW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DIMENSIONS: grid_dims = val[DimW-1:0];
      CFG_LOWER_X:    grid_lower[0] = val;
      CFG_LOWER_Y:    grid_lower[1] = val;
      CFG_LOWER_Z:    grid_lower[2] = val;
      CFG_SIZE_X:     grid_size[0] = val[SizeW-1:0];
      CFG_SIZE_Y:     grid_size[1] = val[SizeW-1:0];
      CFG_SIZE_Z:     grid_size[2] = val[SizeW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_grid(logic [DimW-1:0] dims, logic [CoordW-1:0] lx, ly, lz,
                           logic [SizeW-1:0] sx, sy, sz);
    write_reg(CFG_DIMENSIONS, CoordW'(dims));
    write_reg(CFG_LOWER_X, lx);
    write_reg(CFG_LOWER_Y, ly);
    write_reg(CFG_LOWER_Z, lz);
    write_reg(CFG_SIZE_X, CoordW'(sx));
    write_reg(CFG_SIZE_Y, CoordW'(sy));
    write_reg(CFG_SIZE_Z, CoordW'(sz));
    n_settings++;
  endtask

  task automatic push_req(logic [CoordW-1:0] px, py, pz, logic [BinW-1:0] bx, by, bz);
    bin_query_t q;
    q.pt[0] = px;
    q.pt[1] = py;
    q.pt[2] = pz;
    q.bin[0] = bx;
    q.bin[1] = by;
    q.bin[2] = bz;
    query_q.push_back(q);
  endtask

  // mostly points close to their bin, so the root is exercised unsaturated
  task automatic queue_random(int n);
    bin_query_t q;
    longint lo, span;
    for (int i = 0; i < n; i++) begin
      for (int a = 0; a < NumAxes; a++) begin
        case ($urandom_range(0, 9))
          0:       q.bin[a] = '0;
          1:       q.bin[a] = '1;
          default: q.bin[a] = BinW'($urandom);
        endcase
        if ($urandom_range(0, 99) < 35) begin
          q.pt[a] = $urandom;
        end else begin
          lo = longint'(q.bin[a]) * longint'(grid_size[a]) + longint'(grid_lower[a]);
          span = longint'(grid_size[a]) + 65536;
          q.pt[a] = CoordW'(lo - span + longint'($urandom_range(0, 2 * span)));
        end
      end
      query_q.push_back(q);
    end
  endtask

  task automatic wait_drained();
    wait (query_q.size() == 0 && dist_q.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_grid();
    logic [CoordW-1:0] lw [NumAxes];
    logic [SizeW-1:0]  sw [NumAxes];
    for (int a = 0; a < NumAxes; a++) begin
      case ($urandom_range(0, 3))
        0:       lw[a] = 32'h8000_0000;
        1:       lw[a] = 32'h7FFF_FFFF;
        2:       lw[a] = CoordW'(longint'($urandom_range(0, 2 ** 21)) - 2 ** 20);
        default: lw[a] = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       sw[a] = '0;
        1:       sw[a] = '1;
        2:       sw[a] = SizeW'(1);
        3:       sw[a] = SizeReset;
        default: sw[a] = SizeW'($urandom_range(1, 2 ** SizeW - 1));
      endcase
    end
    load_grid(DimW'($urandom_range(0, 3)), lw[0], lw[1], lw[2], sw[0], sw[1], sw[2]);
  endtask

  initial begin
    grid_dims = DimsReset;
    for (int a = 0; a < NumAxes; a++) begin
      grid_lower[a] = '0;
      grid_size[a] = SizeReset;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    n_settings = 1;

    // reset settings: 3-D, unit bins at the origin
    push_req(32'h0, 32'h0, 32'h0, 10'd0, 10'd0, 10'd0);
    push_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd1023, 10'd1023, 10'd1023);
    push_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 10'd1023, 10'd1023, 10'd1023);
    push_req(32'h0000_8000, 32'h0001_8000, 32'h0002_0000, 10'd0, 10'd1, 10'd2);
    push_req(32'hFFFF_FFFF, 32'h0200_0000, 32'hFFFF_0000, 10'd512, 10'd512, 10'd0);
    wait_drained();

    // 1-D, highest lower bound and widest bins on x; y and z must be ignored
    load_grid(2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, '1, '1, '1);
    push_req(32'h8000_0000, 32'hDEAD_BEEF, 32'h1234_5678, 10'd1023, 10'd1023, 10'd1023);
    push_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 10'd0, 10'd0, 10'd0);
    push_req(32'h7FFF_FFFF, 32'h0, 32'h0, 10'd1023, 10'd5, 10'd7);
    push_req(32'h8000_0000, 32'h0, 32'h0, 10'd0, 10'd0, 10'd0);
    wait_drained();

    // zero dimensions act as 1-D; zero bin size collapses both faces
    load_grid(2'd0, 32'h0001_0000, 32'h0, 32'h0, '0, '0, '0);
    push_req(32'h0003_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 10'd1023);
    push_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 10'd400, 10'd0, 10'd0);
    push_req(32'h0001_0000, 32'h0, 32'h0, 10'd0, 10'd0, 10'd0);
    wait_drained();

    // 2-D, lowest lower bound and smallest nonzero bins; z must be ignored
    load_grid(2'd2, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 21'd1, 21'd1, 21'd1);
    push_req(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 10'd0, 10'd0, 10'd1023);
    push_req(32'h7FFF_FFFF, 32'h8000_0400, 32'h0, 10'd1023, 10'd1023, 10'd0);
    push_req(32'h8000_03FF, 32'h8000_0000, 32'h0, 10'd1023, 10'd1023, 10'd0);
    wait_drained();

    // 3-D full-scale bins from the lowest bound: saturation on several axes
    load_grid(2'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1, '1);
    push_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 10'd0, 10'd1023, 10'd512);
    push_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 10'd1023, 10'd0, 10'd1023);
    push_req(32'h0, 32'h0, 32'h0, 10'd1023, 10'd1023, 10'd1023);
    push_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 10'd0, 10'd0, 10'd0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      random_grid();
      case (ph)
        1: begin
          quiet = 1'b1;
          queue_random(105);
          wait_drained();
          quiet = 1'b0;
        end
        3: begin
          // keep offering while the result side holds off, then pause
          queue_random(80);
          hold_requests++;
          wait_drained();
          queue_random(50);
        end
        default: begin
          queue_random(50);
          wait_drained();
          queue_random(50);
        end
      endcase
      wait_drained();
    end

    repeat (LatencyCyc + 20) @(posedge clk_i);
    if (dist_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", dist_q.size()));
    $display("Checked %0d results for %0d requests over %0d register settings",
             n_checked, n_sent, n_settings);
    $display("(dimensions 0..3, zero and full-scale bins, %0d saturated, stalls on both sides)",
             n_sat);
    if (mismatches == 0) begin
      $display("PASS farthest_bin_corner_distance_top");
    end else begin
      $display("FAIL farthest_bin_corner_distance_top");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", dist_q.size());
    $display("FAIL farthest_bin_corner_distance_top");
    $finish;
  end

endmodule
